// ----- sv/lavm_pkg.sv -----
// Shared types and constants for the look-at view matrix block.
// Used by every module of the block; depends on nothing.
package lavm_pkg;

  localparam int unsigned WordW = 32;
  localparam int unsigned ZW    = 18;
  localparam logic signed [WordW-1:0] OneQ16 = 32'sd65536;
  localparam logic [1:0] ColPos = 2'd3;

  typedef struct packed {
    logic signed [WordW-1:0] pos_x;
    logic signed [WordW-1:0] pos_y;
    logic signed [WordW-1:0] pos_z;
    logic signed [WordW-1:0] tgt_x;
    logic signed [WordW-1:0] tgt_y;
    logic signed [WordW-1:0] tgt_z;
    logic signed [WordW-1:0] up_x;
    logic signed [WordW-1:0] up_y;
    logic signed [WordW-1:0] up_z;
  } in_t;

  typedef struct packed {
    logic [1:0]              column;
    logic signed [WordW-1:0] row1;
    logic signed [WordW-1:0] row2;
    logic signed [WordW-1:0] row3;
    logic signed [WordW-1:0] row4;
    logic                    degenerate;
    logic                    last;
  } out_t;

  typedef struct packed {
    logic [2:0][WordW-1:0] mag;
    logic [2:0]            neg;
    logic [2:0][WordW-1:0] pos;
    logic [2:0][WordW-1:0] up;
    logic                  degen;
  } entry_t;

  typedef struct packed {
    logic push;
    logic pop;
  } qctl_t;

endpackage

// ----- sv/lavm_front.sv -----
// Front end: takes input transfers, forms |pos - tgt| with signs and flags a
// degenerate eye. Depends on lavm_pkg.
module lavm_front (
  input  lavm_pkg::in_t    in_i,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic             full_i,
  output logic             push_o,
  output lavm_pkg::entry_t entry_o
);
  import lavm_pkg::*;

  logic signed [WordW:0] d [3];
  logic signed [WordW:0] nd [3];

  assign d[0] = {in_i.pos_x[WordW-1], in_i.pos_x} - {in_i.tgt_x[WordW-1], in_i.tgt_x};
  assign d[1] = {in_i.pos_y[WordW-1], in_i.pos_y} - {in_i.tgt_y[WordW-1], in_i.tgt_y};
  assign d[2] = {in_i.pos_z[WordW-1], in_i.pos_z} - {in_i.tgt_z[WordW-1], in_i.tgt_z};

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      nd[i]           = -d[i];
      entry_o.neg[i]  = d[i][WordW];
      entry_o.mag[i]  = d[i][WordW] ? nd[i][WordW-1:0] : d[i][WordW-1:0];
    end
    entry_o.pos   = {in_i.pos_z, in_i.pos_y, in_i.pos_x};
    entry_o.up    = {in_i.up_z, in_i.up_y, in_i.up_x};
    entry_o.degen = (d[0] == '0) && (d[1] == '0) && (d[2] == '0);
  end

  assign in_stall_o = full_i;
  assign push_o     = in_valid_i && !full_i;

endmodule

// ----- sv/lavm_queue.sv -----
// Two-entry queue between front and back end.
// Depends on lavm_pkg.
module lavm_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  lavm_pkg::qctl_t  ctl_i,
  input  lavm_pkg::entry_t entry_i,
  output lavm_pkg::entry_t head_o,
  output logic             valid_o,
  output logic             full_o
);
  import lavm_pkg::*;

  entry_t     mem_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (ctl_i.push) wr_q <= ~wr_q;
      if (ctl_i.pop)  rd_q <= ~rd_q;
      cnt_q <= cnt_q + {1'b0, ctl_i.push} - {1'b0, ctl_i.pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.push) mem_q[wr_q] <= entry_i;
  end

  assign head_o  = mem_q[rd_q];
  assign valid_o = cnt_q != 2'd0;
  assign full_o  = cnt_q == 2'd2;

endmodule

// ----- sv/lavm_back.sv -----
// Back end: normalises z (shift, squares, square root, reciprocal), forms the
// cross products on one shared multiplier and sends four columns. Depends on lavm_pkg.
module lavm_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  lavm_pkg::entry_t head_i,
  input  logic             head_valid_i,
  output logic             pop_o,
  output lavm_pkg::out_t   out_o,
  output logic             out_valid_o,
  input  logic             out_stall_i
);
  import lavm_pkg::*;

  localparam logic [2:0] SIdle  = 3'd0;
  localparam logic [2:0] SNorm  = 3'd1;
  localparam logic [2:0] SSq    = 3'd2;
  localparam logic [2:0] SSqrt  = 3'd3;
  localparam logic [2:0] SDiv   = 3'd4;
  localparam logic [2:0] SZmul  = 3'd5;
  localparam logic [2:0] SCross = 3'd6;
  localparam logic [2:0] SEmit  = 3'd7;

  logic [2:0]              state_q;
  logic [5:0]              cnt_q;
  logic                    ph_q;
  logic                    ov_q;
  out_t                    out_q;
  logic [WordW-1:0]        a_q [3];
  logic [WordW-1:0]        big_q;
  logic [2:0]              neg_q;
  logic [2:0][WordW-1:0]   pos_q;
  logic signed [WordW-1:0] up_q [3];
  logic                    degen_q;
  logic [61:0]             s_q;
  logic [62:0]             rem_q, res_q, bit_q;
  logic [30:0]             dr_q;
  logic [33:0]             inv_q;
  logic [63:0]             zacc_q;
  logic signed [ZW-1:0]    z_q [3];
  logic signed [WordW-1:0] x_q [3];
  logic signed [WordW-1:0] y_q [3];
  logic signed [49:0]      prd_q, acc_q;

  logic [WordW-1:0]        hmax;
  logic [59:0]             sq;
  logic [62:0]             rb;
  logic                    rge;
  logic [31:0]             dt;
  logic                    dge;
  logic [1:0]              zc;
  logic [46:0]             zp;
  logic [63:0]             zfull;
  logic [16:0]             zmag;
  logic signed [WordW-1:0] mul_a;
  logic signed [ZW-1:0]    mul_b;
  logic signed [50:0]      dif;
  logic signed [34:0]      dsh;
  logic signed [WordW-1:0] dsat;
  logic                    load;

  always_comb begin
    hmax = head_i.mag[0];
    if (head_i.mag[1] > hmax) hmax = head_i.mag[1];
    if (head_i.mag[2] > hmax) hmax = head_i.mag[2];
    sq    = a_q[cnt_q[1:0]][29:0] * a_q[cnt_q[1:0]][29:0];
    rb    = res_q + bit_q;
    rge   = rem_q >= rb;
    dt    = {dr_q, 1'b0};
    dge   = dt >= {1'b0, res_q[30:0]};
    zc    = cnt_q[2:1];
    zp    = a_q[zc][29:0] * (cnt_q[0] ? inv_q[33:17] : inv_q[16:0]);
    zfull = zacc_q + ({17'd0, zp} << 17);
    zmag  = zfull[62:46];
    unique case (cnt_q[3:0])
      4'd0:    begin mul_a = up_q[1]; mul_b = z_q[2]; end
      4'd1:    begin mul_a = up_q[2]; mul_b = z_q[1]; end
      4'd2:    begin mul_a = up_q[2]; mul_b = z_q[0]; end
      4'd3:    begin mul_a = up_q[0]; mul_b = z_q[2]; end
      4'd4:    begin mul_a = up_q[0]; mul_b = z_q[1]; end
      4'd5:    begin mul_a = up_q[1]; mul_b = z_q[0]; end
      4'd6:    begin mul_a = x_q[2];  mul_b = z_q[1]; end
      4'd7:    begin mul_a = x_q[1];  mul_b = z_q[2]; end
      4'd8:    begin mul_a = x_q[0];  mul_b = z_q[2]; end
      4'd9:    begin mul_a = x_q[2];  mul_b = z_q[0]; end
      4'd10:   begin mul_a = x_q[1];  mul_b = z_q[0]; end
      4'd11:   begin mul_a = x_q[0];  mul_b = z_q[1]; end
      default: begin mul_a = '0;      mul_b = '0;     end
    endcase
    dif = {acc_q[49], acc_q} - {prd_q[49], prd_q};
    dsh = dif[50:16];
    if (dsh > 35'sd2147483647)        dsat = 32'sh7fffffff;
    else if (dsh < -35'sd2147483648)  dsat = 32'sh80000000;
    else                              dsat = dsh[31:0];
    load = (state_q == SEmit) && (!ov_q || !out_stall_i);
  end

  assign pop_o       = load && (cnt_q[1:0] == ColPos);
  assign out_o       = out_q;
  assign out_valid_o = ov_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
      cnt_q   <= 6'd0;
      ph_q    <= 1'b0;
      ov_q    <= 1'b0;
    end else begin
      if (load) ov_q <= 1'b1;
      else if (!out_stall_i) ov_q <= 1'b0;
      unique case (state_q)
        SIdle: if (head_valid_i) begin
          state_q <= head_i.degen ? SCross : SNorm;
          cnt_q   <= 6'd0;
          ph_q    <= 1'b0;
        end
        SNorm: if (!(|big_q[31:30]) && big_q[29]) begin
          state_q <= SSq;
          cnt_q   <= 6'd0;
        end
        SSq: begin
          cnt_q <= cnt_q + 6'd1;
          if (cnt_q == 6'd2) begin
            state_q <= SSqrt;
            cnt_q   <= 6'd0;
          end
        end
        SSqrt: begin
          cnt_q <= cnt_q + 6'd1;
          if (cnt_q == 6'd31) begin
            state_q <= SDiv;
            cnt_q   <= 6'd0;
          end
        end
        SDiv: begin
          cnt_q <= cnt_q + 6'd1;
          if (cnt_q == 6'd33) begin
            state_q <= SZmul;
            cnt_q   <= 6'd0;
          end
        end
        SZmul: begin
          cnt_q <= cnt_q + 6'd1;
          if (cnt_q == 6'd5) begin
            state_q <= SCross;
            cnt_q   <= 6'd0;
            ph_q    <= 1'b0;
          end
        end
        SCross: begin
          ph_q <= ~ph_q;
          if (ph_q) begin
            cnt_q <= cnt_q + 6'd1;
            if (cnt_q == 6'd11) begin
              state_q <= SEmit;
              cnt_q   <= 6'd0;
            end
          end
        end
        SEmit: if (load) begin
          cnt_q <= cnt_q + 6'd1;
          if (cnt_q[1:0] == ColPos) state_q <= SIdle;
        end
        default: state_q <= SIdle;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      SIdle: begin
        for (int i = 0; i < 3; i++) begin
          a_q[i]  <= head_i.mag[i];
          up_q[i] <= head_i.up[i];
          z_q[i]  <= '0;
        end
        big_q   <= hmax;
        neg_q   <= head_i.neg;
        pos_q   <= head_i.pos;
        degen_q <= head_i.degen;
        s_q     <= '0;
      end
      SNorm: begin
        if (|big_q[31:30]) begin
          for (int i = 0; i < 3; i++) a_q[i] <= a_q[i] >> 1;
          big_q <= big_q >> 1;
        end else if (!big_q[29]) begin
          for (int i = 0; i < 3; i++) a_q[i] <= a_q[i] << 1;
          big_q <= big_q << 1;
        end
        res_q <= '0;
        bit_q <= 63'd1 << 62;
      end
      SSq: begin
        s_q   <= s_q + {2'd0, sq};
        rem_q <= {1'b0, s_q + {2'd0, sq}};
      end
      SSqrt: begin
        if (rge) begin
          rem_q <= rem_q - rb;
          res_q <= (res_q >> 1) + bit_q;
        end else begin
          res_q <= res_q >> 1;
        end
        bit_q <= bit_q >> 2;
        dr_q  <= 31'd1 << 28;
        inv_q <= '0;
      end
      SDiv: begin
        dr_q  <= dge ? 31'(dt - {1'b0, res_q[30:0]}) : dt[30:0];
        inv_q <= {inv_q[32:0], dge};
      end
      SZmul: begin
        if (!cnt_q[0]) zacc_q <= {17'd0, zp};
        else z_q[zc] <= neg_q[zc] ? -$signed({1'b0, zmag}) : $signed({1'b0, zmag});
      end
      SCross: begin
        if (!ph_q) prd_q <= mul_a * mul_b;
        else if (!cnt_q[0]) acc_q <= prd_q;
        else if (cnt_q[3:1] < 3'd3) x_q[cnt_q[2:1]] <= dsat;
        else y_q[2'(cnt_q[3:1] - 3'd3)] <= dsat;
      end
      SEmit: if (load) begin
        out_q.column     <= cnt_q[1:0];
        out_q.degenerate <= degen_q;
        out_q.last       <= cnt_q[1:0] == ColPos;
        out_q.row4       <= (cnt_q[1:0] == ColPos) ? OneQ16 : '0;
        unique case (cnt_q[1:0])
          2'd0: begin out_q.row1 <= x_q[0]; out_q.row2 <= x_q[1]; out_q.row3 <= x_q[2]; end
          2'd1: begin out_q.row1 <= y_q[0]; out_q.row2 <= y_q[1]; out_q.row3 <= y_q[2]; end
          2'd2: begin
            out_q.row1 <= WordW'(z_q[0]);
            out_q.row2 <= WordW'(z_q[1]);
            out_q.row3 <= WordW'(z_q[2]);
          end
          2'd3: begin out_q.row1 <= pos_q[0]; out_q.row2 <= pos_q[1]; out_q.row3 <= pos_q[2]; end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

endmodule

// ----- sv/look_at_view_matrix.sv -----
// Top level of the look-at view matrix block: front end, queue and back end.
// Depends on lavm_pkg, lavm_front, lavm_queue and lavm_back.
//
// One input transfer yields four output transfers, the matrix columns in
// order x axis, y axis, z axis, position. For each item the back end does a
// load, normalising (up to 29 shift steps), 3 squares, a 32-step square root,
// a 34-step reciprocal, 6 partial products for z and the cross products on the
// shared 32x18 cross-product multiplier, then sends the four columns. An item
// whose position equals its target skips straight to the cross products.
// Output stalls hold the back end while it sends the columns.
// A two-entry queue holds the item in work and lets the front end take one
// more while the back end works.
module look_at_view_matrix (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  lavm_pkg::in_t  in_i,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  output lavm_pkg::out_t out_o,
  output logic           out_valid_o,
  input  logic           out_stall_i
);
  import lavm_pkg::*;

  entry_t fe_entry, head;
  qctl_t  qctl;
  logic   q_full, q_valid;
  logic   q_push, q_pop;

  assign qctl = '{push: q_push, pop: q_pop};

  lavm_front u_front (
    .in_i       (in_i),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .full_i     (q_full),
    .push_o     (q_push),
    .entry_o    (fe_entry)
  );

  lavm_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (qctl),
    .entry_i (fe_entry),
    .head_o  (head),
    .valid_o (q_valid),
    .full_o  (q_full)
  );

  lavm_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_i       (head),
    .head_valid_i (q_valid),
    .pop_o        (q_pop),
    .out_o        (out_o),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i)
  );

endmodule

// ----- sv/lavm_checker.sv -----
// Port-level checks for look_at_view_matrix, bound to the top level.
// Depends on lavm_pkg.
module lavm_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input lavm_pkg::out_t out_o,
  input logic           out_valid_o,
  input logic           out_stall_i
);
  import lavm_pkg::*;

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_o))
    else $error("stalled result changed");

  a_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_o.last == (out_o.column == ColPos))
    else $error("last flag not on position column");

  a_row4: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_o.row4 == ((out_o.column == ColPos) ? OneQ16 : '0))
    else $error("wrong fourth row");

  a_degen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_o.degenerate && out_o.column != ColPos |->
      out_o.row1 == '0 && out_o.row2 == '0 && out_o.row3 == '0)
    else $error("degenerate axis not zero");

endmodule

bind look_at_view_matrix lavm_checker u_lavm_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_o       (out_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i)
);

// ----- dv/tb.sv -----
// Self-checking testbench for look_at_view_matrix: random and directed camera set-ups,
// each predicted as four matrix columns and compared transfer by transfer.
// Depends on lavm_pkg and look_at_view_matrix.
module tb;
  import lavm_pkg::*;

  logic clk_i;
  logic rst_ni;
  in_t  in_i;
  logic in_valid_i;
  logic in_stall_o;
  out_t out_o;
  logic out_valid_o;
  logic out_stall_i;

  in_t  pending_q[$];
  out_t column_q[$];
  int   errors;
  int   idle_cycles;
  int   burst_left;
  int   gap_left;
  int   hold_left;
  bit   hold_done;
  bit   feeding_done;

  look_at_view_matrix u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_i),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .out_o      (out_o),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  function automatic logic [63:0] root_floor(logic [63:0] s);
    logic [63:0] res;
    logic [63:0] bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > s) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (s >= res + bitv) begin
        s = s - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  function automatic logic signed [31:0] cross_q16(longint p, longint q, longint u,
                                                   longint v);
    longint prod;
    longint sh;
    prod = p * q - u * v;
    sh = prod >>> 16;
    if (sh > 64'sd2147483647) return 32'sh7fffffff;
    if (sh < -64'sd2147483648) return 32'sh80000000;
    return sh[31:0];
  endfunction

  task automatic predict_columns(in_t it);
    longint     p[3], t[3], u[3], d[3], z[3], x[3], y[3];
    logic [63:0] m[3], a[3];
    logic [63:0] big, s, r, inv;
    logic [127:0] wide;
    int k;
    bit degen;
    out_t col;
    p = '{longint'(it.pos_x), longint'(it.pos_y), longint'(it.pos_z)};
    t = '{longint'(it.tgt_x), longint'(it.tgt_y), longint'(it.tgt_z)};
    u = '{longint'(it.up_x), longint'(it.up_y), longint'(it.up_z)};
    big = 0;
    for (int i = 0; i < 3; i++) begin
      d[i] = p[i] - t[i];
      m[i] = d[i] < 0 ? -d[i] : d[i];
      if (m[i] > big) big = m[i];
    end
    degen = (big == 0);
    z = '{0, 0, 0};
    if (!degen) begin
      k = 0;
      if (big >= (64'd1 << 30)) begin
        while ((big >> k) >= (64'd1 << 30)) k++;
        for (int i = 0; i < 3; i++) a[i] = m[i] >> k;
      end else begin
        while ((big << (k + 1)) < (64'd1 << 30)) k++;
        for (int i = 0; i < 3; i++) a[i] = m[i] << k;
      end
      s = 0;
      for (int i = 0; i < 3; i++) s = s + a[i] * a[i];
      r = root_floor(s);
      inv = (64'd1 << 62) / r;
      for (int i = 0; i < 3; i++) begin
        wide = {64'd0, a[i]} * {64'd0, inv};
        z[i] = d[i] < 0 ? -longint'(wide >> 46) : longint'(wide >> 46);
      end
    end
    x[0] = longint'(cross_q16(u[1], z[2], u[2], z[1]));
    x[1] = longint'(cross_q16(u[2], z[0], u[0], z[2]));
    x[2] = longint'(cross_q16(u[0], z[1], u[1], z[0]));
    y[0] = longint'(cross_q16(z[1], x[2], z[2], x[1]));
    y[1] = longint'(cross_q16(z[2], x[0], z[0], x[2]));
    y[2] = longint'(cross_q16(z[0], x[1], z[1], x[0]));
    for (int c = 0; c < 4; c++) begin
      col.column = c[1:0];
      col.degenerate = degen;
      col.last = (c == 3);
      col.row4 = 0;
      case (c)
        0: begin col.row1 = 32'(x[0]); col.row2 = 32'(x[1]); col.row3 = 32'(x[2]); end
        1: begin col.row1 = 32'(y[0]); col.row2 = 32'(y[1]); col.row3 = 32'(y[2]); end
        2: begin col.row1 = 32'(z[0]); col.row2 = 32'(z[1]); col.row3 = 32'(z[2]); end
        default: begin
          col.row1 = 32'(p[0]); col.row2 = 32'(p[1]); col.row3 = 32'(p[2]);
          col.row4 = OneQ16;
        end
      endcase
      column_q.push_back(col);
    end
  endtask

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 5))
      0: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
      1: return $signed($urandom_range(0, 8)) - 4 <<< 16;
      2: return $urandom_range(0, 1) ? 32'h0 : 32'h00010000;
      3: return {{16{$urandom_range(0, 1) == 1}}, 16'($urandom)};
      default: return $urandom;
    endcase
  endfunction

  task automatic add_item(logic [31:0] px, py, pz, tx, ty, tz, ux, uy, uz);
    in_t it;
    it = '{px, py, pz, tx, ty, tz, ux, uy, uz};
    pending_q.push_back(it);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_i <= '0;
      burst_left <= 0;
      gap_left <= 0;
    end else if (!(in_valid_i && in_stall_o)) begin
      if (in_valid_i) predict_columns(in_i);
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        in_valid_i <= 1'b0;
      end else if (pending_q.size() > 0) begin
        in_i <= pending_q.pop_front();
        in_valid_i <= 1'b1;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 12);
          gap_left <= $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 300);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_valid_i <= 1'b0;
        feeding_done <= 1'b1;
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      hold_left <= 0;
      hold_done <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (column_q.size() == 0) begin
          $error("column transfer with nothing expected");
          errors++;
        end else begin
          out_t e;
          e = column_q.pop_front();
          if (out_o.column !== e.column) begin
            $error("column exp %0d got %0d", e.column, out_o.column);
            errors++;
          end
          if (out_o.row1 !== e.row1) begin
            $error("row1 exp %0d got %0d", e.row1, out_o.row1);
            errors++;
          end
          if (out_o.row2 !== e.row2) begin
            $error("row2 exp %0d got %0d", e.row2, out_o.row2);
            errors++;
          end
          if (out_o.row3 !== e.row3) begin
            $error("row3 exp %0d got %0d", e.row3, out_o.row3);
            errors++;
          end
          if (out_o.row4 !== e.row4) begin
            $error("row4 exp %0d got %0d", e.row4, out_o.row4);
            errors++;
          end
          if (out_o.degenerate !== e.degenerate) begin
            $error("degenerate exp %0d got %0d", e.degenerate, out_o.degenerate);
            errors++;
          end
          if (out_o.last !== e.last) begin
            $error("last exp %0d got %0d", e.last, out_o.last);
            errors++;
          end
        end
      end
      if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_stall_i <= 1'b1;
      end else if (!hold_done && out_valid_o && column_q.size() > 4) begin
        hold_done <= 1'b1;
        hold_left <= 1500;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= ($urandom_range(0, 3) == 0) && ($urandom_range(0, 1) == 0);
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 10000) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  initial begin
    logic [31:0] w[9];
    errors = 0;
    feeding_done = 1'b0;
    idle_cycles = 0;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_i = '0;
    out_stall_i = 1'b0;
    // directed: degenerate, extremes, parallel and zero up, saturation
    add_item(0, 0, 0, 0, 0, 0, 0, 32'h10000, 0);
    add_item(32'h50000, 1, 2, 32'h50000, 1, 2, 3, 4, 5);
    add_item(32'h10000, 0, 0, 0, 0, 0, 0, 32'h10000, 0);
    add_item(0, 0, 32'h10000, 0, 0, 0, 0, 32'h10000, 0);
    add_item(0, 0, 32'h10000, 0, 0, 0, 0, 0, 32'h10000);
    add_item(0, 0, 32'h10000, 0, 0, 0, 0, 0, 0);
    add_item(32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
             32'h80000000, 32'h80000000, 32'h80000000,
             32'h7fffffff, 32'h80000000, 32'h7fffffff);
    add_item(32'h80000000, 32'h80000000, 32'h80000000,
             32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
             32'h80000000, 32'h80000000, 32'h80000000);
    add_item(1, 0, 0, 0, 0, 0, 32'h80000000, 32'h7fffffff, 32'h80000000);
    add_item(0, 0, 1, 0, 0, 0, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
    add_item(32'hffffffff, 32'hffffffff, 32'hffffffff, 0, 0, 0, 1, 2, 3);
    add_item(32'h30000, 32'h40000, 0, 0, 0, 0, 0, 0, 32'h10000);
    add_item(32'h12345678, 32'hedcba987, 32'h0f0f0f0f, 32'hf0f0f0f0,
             32'h55555555, 32'haaaaaaaa, 32'h00010000, 32'hffff0000, 32'h00008000);
    for (int n = 0; n < 340; n++) begin
      for (int j = 0; j < 9; j++) w[j] = rand_word();
      if ($urandom_range(0, 19) == 0) begin
        for (int j = 0; j < 3; j++) w[3 + j] = w[j];
      end
      add_item(w[0], w[1], w[2], w[3], w[4], w[5], w[6], w[7], w[8]);
    end
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    wait (feeding_done && !in_valid_i && column_q.size() == 0);
    repeat (200) @(posedge clk_i);
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule
